/* rtl/ibcp_pkg.sv */
// Shared types, codes and constants for the burst check and packetizer.
`timescale 1ns / 1ps

package ibcp_pkg;

	localparam int FRAME_WORDS_DEF = 17;

	localparam logic [15:0] PWM_TOP_RST = 16'd62499;
	localparam logic [7:0]  LIMIT_RST   = 8'd5;
	localparam logic [7:0]  RUN_MAX     = 8'd255;

	// register indexes (paddr[2])
	localparam logic REG_PWM_TOP = 1'b0;
	localparam logic REG_LIMIT   = 1'b1;

	// rate scaling: span = 2^17 * DIV_BASE
	localparam logic signed [32:0] RATE_CLAMP  = 33'sd1310720000;
	localparam logic signed [32:0] RATE_OFFSET = 33'sd1638400000;
	localparam logic [16:0]        DIV_BASE    = 17'd25000;
	// floor(2^32 / DIV_BASE): quotient estimate is exact or one low
	localparam logic [17:0]        DIV_RECIP   = 18'd171798;
	// estimate step, then remainder step
	localparam int                 DIV_STEPS   = 2;

	// micro-operations
	localparam logic [2:0] OP_NOP   = 3'd0;
	localparam logic [2:0] OP_CHECK = 3'd1;
	localparam logic [2:0] OP_MUL   = 3'd2;
	localparam logic [2:0] OP_DIV   = 3'd3;
	localparam logic [2:0] OP_LEVEL = 3'd4;
	localparam logic [2:0] OP_EMIT  = 3'd5;

	// sequencing conditions
	localparam logic [1:0] COND_NEXT     = 2'd0;
	localparam logic [1:0] COND_IF_BAD   = 2'd1;
	localparam logic [1:0] COND_DIV_LOOP = 2'd2;
	localparam logic [1:0] COND_EMIT_END = 2'd3;

	typedef struct packed {
		logic [2:0] op;
		logic [1:0] cond;
		logic [2:0] target;
	} uword_t;

	typedef struct packed {
		logic [2:0] op;
	} ctrl_t;

	typedef struct packed {
		logic frame_bad;
		logic div_last;
		logic byte_last;
	} stat_t;

	typedef struct packed {
		logic               kind;
		logic [15:0]        burst_word;
		logic [31:0]        sample_time;
		logic signed [15:0] left_count;
		logic signed [15:0] right_count;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  packet_byte;
		logic        last_byte;
		logic        frame_ok;
		logic [15:0] pwm_level;
		logic        reset_request;
	} out_item_t;

endpackage

/* rtl/ibcp_useq.sv */
// Microcode sequencer: step counter, control store and conditional jumps.
`timescale 1ns / 1ps

module ibcp_useq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           go,
	input  ibcp_pkg::stat_t stat,
	output ibcp_pkg::ctrl_t ctrl,
	output logic           running
);

	localparam logic [2:0] ST_CHECK = 3'd0;
	localparam logic [2:0] ST_MUL   = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_LEVEL = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;

	function automatic ibcp_pkg::uword_t ucode(input logic [2:0] step);
		ibcp_pkg::uword_t w;
		case (step)
			ST_CHECK: w = '{ibcp_pkg::OP_CHECK, ibcp_pkg::COND_IF_BAD,   ST_EMIT};
			ST_MUL:   w = '{ibcp_pkg::OP_MUL,   ibcp_pkg::COND_NEXT,     ST_DIV};
			ST_DIV:   w = '{ibcp_pkg::OP_DIV,   ibcp_pkg::COND_DIV_LOOP, ST_DIV};
			ST_LEVEL: w = '{ibcp_pkg::OP_LEVEL, ibcp_pkg::COND_NEXT,     ST_EMIT};
			ST_EMIT:  w = '{ibcp_pkg::OP_EMIT,  ibcp_pkg::COND_EMIT_END, ST_EMIT};
			default:  w = '{ibcp_pkg::OP_NOP,   ibcp_pkg::COND_EMIT_END, ST_CHECK};
		endcase
		return w;
	endfunction

	logic [2:0]       step_q;
	logic             run_q;
	ibcp_pkg::uword_t uw;

	assign uw      = ucode(step_q);
	assign ctrl.op = run_q ? uw.op : ibcp_pkg::OP_NOP;
	assign running = run_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_CHECK;
			run_q  <= 1'b0;
		end else if (go) begin
			step_q <= ST_CHECK;
			run_q  <= 1'b1;
		end else if (run_q) begin
			case (uw.cond)
				ibcp_pkg::COND_NEXT: step_q <= step_q + 3'd1;
				ibcp_pkg::COND_IF_BAD: begin
					step_q <= stat.frame_bad ? uw.target : step_q + 3'd1;
				end
				ibcp_pkg::COND_DIV_LOOP: begin
					step_q <= stat.div_last ? step_q + 3'd1 : uw.target;
				end
				ibcp_pkg::COND_EMIT_END: begin
					if (stat.byte_last) begin
						run_q  <= 1'b0;
						step_q <= ST_CHECK;
					end else begin
						step_q <= uw.target;
					end
				end
				default: run_q <= 1'b0;
			endcase
		end
	end

endmodule

/* rtl/ibcp_rate.sv */
// Rate level datapath: clamp and bias, 32x16 multiply, reciprocal divide by the span.
`timescale 1ns / 1ps

module ibcp_rate (
	input  logic            clk,
	input  logic            arst_n,
	input  ibcp_pkg::ctrl_t ctrl,
	input  logic [15:0]     rate_lo,
	input  logic [15:0]     rate_hi,
	input  logic [15:0]     pwm_top,
	output logic [15:0]     level,
	output logic            div_last
);

	localparam int CW = $clog2(ibcp_pkg::DIV_STEPS);

	logic signed [32:0] raw;
	logic signed [32:0] clamped;
	logic signed [32:0] biased;
	logic [31:0]        bias_q;
	logic [47:0]        prod;
	logic [30:0]        dvd_q;
	logic [48:0]        recip;
	logic [30:0]        back;
	logic [15:0]        est_q;
	logic [15:0]        rem_q;
	logic [CW-1:0]      cnt_q;
	logic               ge;

	always_comb begin
		raw = 33'(signed'({rate_hi, rate_lo}));
		if (raw > ibcp_pkg::RATE_CLAMP)
			clamped = ibcp_pkg::RATE_CLAMP;
		else if (raw < -ibcp_pkg::RATE_CLAMP)
			clamped = -ibcp_pkg::RATE_CLAMP;
		else
			clamped = raw;
		biased = clamped + ibcp_pkg::RATE_OFFSET;
	end

	assign prod  = 48'(bias_q) * 48'(pwm_top);
	// dividend (num >> 17) is below 2^31, so the estimate is q or q-1
	assign recip = 49'(dvd_q) * 49'(ibcp_pkg::DIV_RECIP);
	assign back  = 31'(est_q) * 31'(ibcp_pkg::DIV_BASE);
	assign ge    = rem_q >= ibcp_pkg::DIV_BASE;

	assign level    = est_q + {15'd0, ge};
	assign div_last = (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case (ctrl.op)
				ibcp_pkg::OP_MUL: cnt_q <= CW'(ibcp_pkg::DIV_STEPS - 1);
				ibcp_pkg::OP_DIV: cnt_q <= cnt_q - 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctrl.op)
			ibcp_pkg::OP_CHECK: bias_q <= biased[31:0];
			ibcp_pkg::OP_MUL:   dvd_q  <= prod[47:17];
			ibcp_pkg::OP_DIV: begin
				// remainder uses the estimate from the previous divide step
				est_q <= recip[47:32];
				rem_q <= 16'(dvd_q - back);
			end
			default: ;
		endcase
	end

endmodule

/* rtl/imu_burst_check_and_packetize.sv */
// Top level: burst word capture, checksum, suspicious-frame tracking and packet emission.
//
// Usage: drive item and raise start; a transaction is taken at a clock edge with
// start high and busy low. Kind-0 items carry burst words in order; a kind-1 item
// clears the reset request. Non-final words are absorbed while busy stays low.
// The final word starts the control program and raises busy: one check step, then for
// a good frame one multiply step, two divide steps and a level step, then one step per
// packet byte (2*(FRAME_WORDS-2)+12 bytes, 42 at the default). The bytes are registered
// and follow on consecutive cycles, each shown for one cycle with result_valid high.
// The receiver cannot stall; results are not held. The one-byte-per-step CRC and emit
// path sets most of the busy time.
// Reset clears word position, checksum, level, suspicious run and request flag and
// loads pwm_top 62499 and suspicious_limit 5. The APB port writes both registers at
// byte addresses 0 and 4 and should be written only while idle.
`timescale 1ns / 1ps

module imu_burst_check_and_packetize #(
	parameter int FRAME_WORDS = ibcp_pkg::FRAME_WORDS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  ibcp_pkg::in_item_t  item,
	output logic                result_valid,
	output ibcp_pkg::out_item_t result,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	localparam int DW         = FRAME_WORDS - 2;
	localparam int DATA_BYTES = 2 * DW;
	localparam int PKT_LEN    = DATA_BYTES + 12;
	localparam int CRC_LEN    = PKT_LEN - 4;
	localparam int PW         = $clog2(FRAME_WORDS);
	localparam int SW         = $clog2(DW);
	localparam int BW         = $clog2(PKT_LEN);

	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++)
			c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
		return c;
	endfunction

	// configuration
	logic [15:0] pwm_top_q;
	logic [7:0]  limit_q;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == ibcp_pkg::REG_LIMIT) ? {24'd0, limit_q} : {16'd0, pwm_top_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwm_top_q <= ibcp_pkg::PWM_TOP_RST;
			limit_q   <= ibcp_pkg::LIMIT_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				ibcp_pkg::REG_PWM_TOP: pwm_top_q <= pwdata[15:0];
				ibcp_pkg::REG_LIMIT:   limit_q   <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// word capture
	logic [15:0]        store_q [DW];
	logic [PW-1:0]      pos_q;
	logic [15:0]        sum_q;
	logic [15:0]        final_q;
	logic [31:0]        time_q;
	logic [15:0]        left_q;
	logic [15:0]        right_q;
	logic               accept;
	logic               final_word;
	logic [PW-1:0]      wr_pos;

	assign accept     = start && !busy;
	assign final_word = (pos_q == PW'(FRAME_WORDS - 1));
	assign wr_pos     = pos_q - 1'b1;

	// sequencer
	ibcp_pkg::ctrl_t ctrl;
	ibcp_pkg::stat_t stat;
	logic            running;
	logic            go;

	assign go   = accept && !item.kind && final_word;
	assign busy = running;

	ibcp_useq u_useq (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (go),
		.stat    (stat),
		.ctrl    (ctrl),
		.running (running)
	);

	// frame status
	logic        ok_q;
	logic [7:0]  run_q;
	logic        flag_q;
	logic [15:0] level_q;
	logic        ok_now;
	logic        susp;
	logic [7:0]  run_nx;
	logic [15:0] calc_level;
	logic        div_last;
	logic [BW-1:0] byte_idx_q;

	assign ok_now = (sum_q == final_q);
	assign susp   = !ok_now || (sum_q == 16'd0);
	assign run_nx = !susp ? 8'd0 : (run_q == ibcp_pkg::RUN_MAX) ? run_q : run_q + 8'd1;

	// sum and final word hold while busy, so the check step can branch on them directly
	assign stat.frame_bad = !ok_now;
	assign stat.div_last  = div_last;
	assign stat.byte_last = (byte_idx_q == BW'(PKT_LEN - 1));

	ibcp_rate u_rate (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.rate_lo  (store_q[5]),
		.rate_hi  (store_q[6]),
		.pwm_top  (pwm_top_q),
		.level    (calc_level),
		.div_last (div_last)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			sum_q   <= '0;
			run_q   <= '0;
			flag_q  <= 1'b0;
			level_q <= '0;
			ok_q    <= 1'b0;
		end else begin
			if (accept) begin
				if (item.kind) begin
					flag_q <= 1'b0;
				end else if (pos_q == '0) begin
					sum_q <= '0;
					pos_q <= PW'(1);
				end else if (!final_word) begin
					sum_q <= sum_q + {8'd0, item.burst_word[7:0]} + {8'd0, item.burst_word[15:8]};
					pos_q <= pos_q + 1'b1;
				end else begin
					pos_q <= '0;
				end
			end
			case (ctrl.op)
				ibcp_pkg::OP_CHECK: begin
					ok_q  <= ok_now;
					run_q <= run_nx;
					if (run_nx >= limit_q)
						flag_q <= 1'b1;
				end
				ibcp_pkg::OP_LEVEL: level_q <= calc_level;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !item.kind) begin
			if (pos_q != '0 && !final_word)
				store_q[SW'(wr_pos)] <= item.burst_word;
			if (final_word) begin
				final_q <= item.burst_word;
				time_q  <= item.sample_time;
				left_q  <= item.left_count;
				right_q <= item.right_count;
			end
		end
	end

	// packet emission
	logic [31:0] crc_q;
	logic [7:0]  pkt_byte;
	logic [15:0] data_word;
	logic [95:0] tail;
	logic [3:0]  tail_idx;
	logic        out_valid_q;
	ibcp_pkg::out_item_t out_q;

	assign tail     = {crc_q, right_q, left_q, time_q};
	assign tail_idx = 4'(byte_idx_q - BW'(DATA_BYTES));

	always_comb begin
		data_word = store_q[SW'(byte_idx_q[BW-1:1])];
		if (byte_idx_q < BW'(DATA_BYTES)) begin
			if (ok_q)
				pkt_byte = byte_idx_q[0] ? data_word[15:8] : data_word[7:0];
			else
				// bad frame: all zero except data word 0 = 1
				pkt_byte = (byte_idx_q == '0) ? 8'd1 : 8'd0;
		end else begin
			pkt_byte = tail[8*tail_idx +: 8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			byte_idx_q  <= '0;
		end else begin
			out_valid_q <= (ctrl.op == ibcp_pkg::OP_EMIT);
			case (ctrl.op)
				ibcp_pkg::OP_CHECK: byte_idx_q <= '0;
				ibcp_pkg::OP_EMIT:  byte_idx_q <= byte_idx_q + 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctrl.op)
			ibcp_pkg::OP_CHECK: crc_q <= 32'hFFFFFFFF;
			ibcp_pkg::OP_EMIT: begin
				if (byte_idx_q < BW'(CRC_LEN))
					crc_q <= crc_byte(crc_q, pkt_byte);
				out_q.packet_byte   <= pkt_byte;
				out_q.last_byte     <= stat.byte_last;
				out_q.frame_ok      <= ok_q;
				out_q.pwm_level     <= level_q;
				out_q.reset_request <= flag_q;
			end
			default: ;
		endcase
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule
